// File: sv/ckdc_pkg.sv
// Shared constants and types for the contour keypoint direction coder.
package ckdc_pkg;

	// Q16 tangents of 22.5, 45 and 67.5 degrees (pi taken as 3.14)
	localparam int unsigned TAN_BITS = 18;
	localparam logic [TAN_BITS-1:0] Q16_T22 = 18'd27131;
	localparam logic [TAN_BITS-1:0] Q16_T45 = 18'd65484;
	localparam logic [TAN_BITS-1:0] Q16_T67 = 18'd157951;
	localparam int unsigned Q_SHIFT = 16;

	// Step pair value before any keypoint candidate is taken
	localparam int STEP_RESET = 99;

	// Register map (index = paddr[2])
	localparam logic REG_SIDE = 1'b0;
	localparam logic REG_NEAR = 1'b1;

	localparam logic [1:0] SIDE_RESET = 2'd0;
	localparam logic [1:0] SIDE_RIGHT = 2'd3;
	localparam logic [7:0] NEAR_RESET = 8'd5;

	// Octant codes, steepest positive first
	typedef enum logic [2:0] {
		DIR_P67 = 3'd0,
		DIR_P45 = 3'd1,
		DIR_P22 = 3'd2,
		DIR_P00 = 3'd3,
		DIR_N00 = 3'd4,
		DIR_N22 = 3'd5,
		DIR_N45 = 3'd6,
		DIR_N67 = 3'd7
	} dir_code_t;

	// Per-keypoint tag carried with the coordinates
	typedef struct packed {
		logic [7:0] index;
		logic       has_dir;
		logic       is_last;
	} key_tag_t;

	// Queue write strobes from the front end
	typedef struct packed {
		logic first;
		logic second;
	} push_t;

endpackage

// File: sv/ckdc_front.sv
// Front end: point window, keypoint selection and queue requests.
module ckdc_front #(
	parameter int COORD_BITS = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [COORD_BITS-1:0]   row,
	input  logic [COORD_BITS-1:0]   col,
	input  logic                    last,
	input  logic [1:0]              side,
	input  logic [7:0]              near_distance,
	output ckdc_pkg::push_t         push,
	output logic [4*COORD_BITS+$bits(ckdc_pkg::key_tag_t)-1:0] ev0,
	output logic [4*COORD_BITS+$bits(ckdc_pkg::key_tag_t)-1:0] ev1
);
	localparam int SW   = (COORD_BITS + 1 > 8) ? COORD_BITS + 1 : 8;
	localparam int CMPW = COORD_BITS + 10;

	logic [COORD_BITS-1:0] win_row_q [3];
	logic [COORD_BITS-1:0] win_col_q [3];
	logic [7:0]            pidx_q;
	logic [7:0]            kc_q;
	logic [COORD_BITS-1:0] lk_row_q, lk_col_q;
	logic signed [SW-1:0]  psb_q, psa_q;

	logic [COORD_BITS-1:0] ax0, ax1, ax2;
	logic signed [SW-1:0]  s0, s1;
	logic signed [CMPW-1:0] drow, dcol, nd;
	logic same, near, rep, first, cand, ea_v;
	logic [COORD_BITS-1:0] ea_row, ea_col, eb_prow, eb_pcol;
	ckdc_pkg::key_tag_t    ea_tag, eb_tag;
	logic [4*COORD_BITS+$bits(ckdc_pkg::key_tag_t)-1:0] ea, eb;

	always_comb begin
		ax0 = side[0] ? win_col_q[0] : win_row_q[0];
		ax1 = side[0] ? win_col_q[1] : win_row_q[1];
		ax2 = side[0] ? win_col_q[2] : win_row_q[2];
		s0 = $signed(SW'(ax1)) - $signed(SW'(ax0));
		s1 = $signed(SW'(ax2)) - $signed(SW'(ax1));
		same = (s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0) || (s0 == 0 && s1 == 0);
		drow = $signed(CMPW'(win_row_q[1])) - $signed(CMPW'(lk_row_q));
		dcol = $signed(CMPW'(win_col_q[1])) - $signed(CMPW'(lk_col_q));
		nd   = $signed(CMPW'(near_distance));
		near = (dcol <= nd) && (drow <= nd);
		rep  = (psb_q == s0) && (psa_q == s1);
		first = (pidx_q == 8'd0);
		cand  = (pidx_q >= 8'd3) && !same && !near && !rep;
		ea_v  = first || cand;

		ea_row = first ? row : win_row_q[1];
		ea_col = first ? col : win_col_q[1];
		ea_tag.index   = kc_q;
		ea_tag.has_dir = !first;
		ea_tag.is_last = 1'b0;
		ea = {ea_tag, lk_col_q, lk_row_q, ea_col, ea_row};

		// last keypoint measures from whatever was emitted just before it
		eb_prow = ea_v ? ea_row : lk_row_q;
		eb_pcol = ea_v ? ea_col : lk_col_q;
		eb_tag.index   = kc_q + 8'(ea_v);
		eb_tag.has_dir = 1'b1;
		eb_tag.is_last = 1'b1;
		eb = {eb_tag, eb_pcol, eb_prow, col, row};

		push.first  = accept && (ea_v || last);
		push.second = accept && ea_v && last;
		ev0 = ea_v ? ea : eb;
		ev1 = eb;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				win_row_q[i] <= '0;
				win_col_q[i] <= '0;
			end
			pidx_q   <= '0;
			kc_q     <= '0;
			lk_row_q <= '0;
			lk_col_q <= '0;
			psb_q    <= SW'(ckdc_pkg::STEP_RESET);
			psa_q    <= SW'(ckdc_pkg::STEP_RESET);
		end else if (accept) begin
			if (last) begin
				// end of profile: back to the idle state
				for (int i = 0; i < 3; i++) begin
					win_row_q[i] <= '0;
					win_col_q[i] <= '0;
				end
				pidx_q   <= '0;
				kc_q     <= '0;
				lk_row_q <= '0;
				lk_col_q <= '0;
				psb_q    <= SW'(ckdc_pkg::STEP_RESET);
				psa_q    <= SW'(ckdc_pkg::STEP_RESET);
			end else begin
				win_row_q[0] <= win_row_q[1];
				win_row_q[1] <= win_row_q[2];
				win_row_q[2] <= row;
				win_col_q[0] <= win_col_q[1];
				win_col_q[1] <= win_col_q[2];
				win_col_q[2] <= col;
				if (pidx_q != 8'hFF) begin
					pidx_q <= pidx_q + 8'd1;
				end
				if (ea_v) begin
					lk_row_q <= ea_row;
					lk_col_q <= ea_col;
					kc_q     <= kc_q + 8'd1;
				end
				if (cand) begin
					psb_q <= s0;
					psa_q <= s1;
				end
			end
		end
	end

endmodule

// File: sv/ckdc_queue.sv
// Four-entry keypoint queue: up to two writes and one read per cycle.
module ckdc_queue #(
	parameter int DW = 42
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ckdc_pkg::push_t push,
	input  logic [DW-1:0]   d0,
	input  logic [DW-1:0]   d1,
	input  logic            pop,
	output logic [DW-1:0]   head,
	output logic            head_v,
	output logic            room
);
	localparam int DEPTH = 4;
	localparam int AW    = $clog2(DEPTH);

	logic [DW-1:0] mem_q [DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic          do_pop;

	assign do_pop = pop && (cnt_q != '0);
	assign head   = mem_q[rd_q];
	assign head_v = (cnt_q != '0);
	// room for the two entries one point can cause
	assign room   = (cnt_q <= (AW+1)'(DEPTH - 2));

	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (push.first && wr_q == AW'(i)) begin
				mem_q[i] <= d0;
			end
			if (push.second && (wr_q + AW'(1)) == AW'(i)) begin
				mem_q[i] <= d1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + AW'(push.first) + AW'(push.second);
			rd_q  <= rd_q + AW'(do_pop);
			cnt_q <= cnt_q + (AW+1)'(push.first) + (AW+1)'(push.second)
				- (AW+1)'(do_pop);
		end
	end

endmodule

// File: sv/ckdc_back.sv
// Back end: octant code pipeline and output register.
module ckdc_back #(
	parameter int COORD_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [4*COORD_BITS+$bits(ckdc_pkg::key_tag_t)-1:0] head,
	input  logic        head_v,
	output logic        pop,
	input  logic [1:0]  side,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  key_row,
	output logic [7:0]  key_col,
	output logic [7:0]  key_index,
	output logic        has_direction,
	output logic [2:0]  direction,
	output logic        last_key
);
	localparam int CB = COORD_BITS;
	localparam int PW = CB + ckdc_pkg::TAN_BITS;

	ckdc_pkg::key_tag_t   h_tag;
	logic [CB-1:0]        h_row, h_col, h_prow, h_pcol;
	logic signed [CB:0]   dr, dc, num, den;

	logic                 v_s1, v_s2, out_v_q;
	logic                 en1, en2, en3;
	logic [CB-1:0]        a_s1, b_s1;
	logic                 num0_s1, den0_s1, neg_s1;
	logic [CB-1:0]        row_s1, col_s1, row_s2, col_s2;
	ckdc_pkg::key_tag_t   tag_s1, tag_s2;
	logic                 num0_s2, den0_s2, neg_s2;
	logic [PW-1:0]        q_s2, p22_s2, p45_s2, p67_s2;
	ckdc_pkg::dir_code_t  code;
	logic [7:0]           row_q, col_q;
	ckdc_pkg::key_tag_t   tag_q;
	ckdc_pkg::dir_code_t  dir_q;

	assign {h_tag, h_pcol, h_prow, h_col, h_row} = head;

	assign en3 = !out_v_q || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign pop = head_v && en1;

	always_comb begin
		dr  = $signed((CB+1)'(h_row)) - $signed((CB+1)'(h_prow));
		dc  = $signed((CB+1)'(h_pcol)) - $signed((CB+1)'(h_col));
		num = side[0] ? dc : dr;
		den = side[0] ? dr : dc;
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1    <= CB'(num[CB] ? -num : num);
			b_s1    <= CB'(den[CB] ? -den : den);
			num0_s1 <= (num == '0);
			den0_s1 <= (den == '0);
			// mirror on the right side
			neg_s1  <= (num[CB] != den[CB]) ^ (side == ckdc_pkg::SIDE_RIGHT);
			row_s1  <= h_row;
			col_s1  <= h_col;
			tag_s1  <= h_tag;
		end
		if (en2) begin
			q_s2    <= PW'(a_s1) << ckdc_pkg::Q_SHIFT;
			p22_s2  <= PW'(ckdc_pkg::Q16_T22) * PW'(b_s1);
			p45_s2  <= PW'(ckdc_pkg::Q16_T45) * PW'(b_s1);
			p67_s2  <= PW'(ckdc_pkg::Q16_T67) * PW'(b_s1);
			num0_s2 <= num0_s1;
			den0_s2 <= den0_s1;
			neg_s2  <= neg_s1;
			row_s2  <= row_s1;
			col_s2  <= col_s1;
			tag_s2  <= tag_s1;
		end
		if (en3) begin
			row_q <= 8'(row_s2);
			col_q <= 8'(col_s2);
			tag_q <= tag_s2;
			dir_q <= code;
		end
	end

	always_comb begin
		if (!tag_s2.has_dir) begin
			code = ckdc_pkg::DIR_P67;
		end else if (num0_s2) begin
			code = ckdc_pkg::DIR_P00;
		end else if (den0_s2) begin
			code = ckdc_pkg::DIR_P67;
		end else if (!neg_s2) begin
			if (q_s2 >= p67_s2)      code = ckdc_pkg::DIR_P67;
			else if (q_s2 >= p45_s2) code = ckdc_pkg::DIR_P45;
			else if (q_s2 >= p22_s2) code = ckdc_pkg::DIR_P22;
			else                     code = ckdc_pkg::DIR_P00;
		end else begin
			if (q_s2 <= p22_s2)      code = ckdc_pkg::DIR_N00;
			else if (q_s2 <= p45_s2) code = ckdc_pkg::DIR_N22;
			else if (q_s2 <= p67_s2) code = ckdc_pkg::DIR_N45;
			else                     code = ckdc_pkg::DIR_N67;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= head_v;
			if (en2) v_s2 <= v_s1;
			if (en3) out_v_q <= v_s2;
		end
	end

	assign out_valid     = out_v_q;
	assign key_row       = row_q;
	assign key_col       = col_q;
	assign key_index     = tag_q.index;
	assign has_direction = tag_q.has_dir;
	assign direction     = dir_q;
	assign last_key      = tag_q.is_last;

endmodule

// File: sv/contour_keypoint_direction_coder.sv
// Top level: configuration registers, front end, keypoint queue and back end.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------------------
//  points    | in_valid / in_stall | point_row, point_col, last_point
//  keypoints | out_valid/out_stall | key_row, key_col, key_index, has_direction,
//            |                     |   direction, last_key
//  config    | APB psel/penable    | paddr, pwdata, prdata (side @0, near_distance @4)
//
// One point per cycle is taken while the four-entry queue has room for two keypoints.
// The back end codes one keypoint per cycle while out_stall is low; a point that closes
// the profile with an inner keypoint yields two keypoints. With an empty queue and no
// output stall, out_valid rises once the keypoint is written to the output register.
// Reset clears all profile state; a stalled output holds while points keep queuing.
module contour_keypoint_direction_coder #(
	parameter int COORD_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  point_row,
	input  logic [7:0]  point_col,
	input  logic        last_point,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  key_row,
	output logic [7:0]  key_col,
	output logic [7:0]  key_index,
	output logic        has_direction,
	output logic [2:0]  direction,
	output logic        last_key,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int EW = 4*COORD_BITS + $bits(ckdc_pkg::key_tag_t);

	logic [1:0]      side_q;
	logic [7:0]      near_q;
	logic            accept, room, head_v, pop;
	ckdc_pkg::push_t push;
	logic [EW-1:0]   ev0, ev1, head;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= ckdc_pkg::SIDE_RESET;
			near_q <= ckdc_pkg::NEAR_RESET;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				ckdc_pkg::REG_SIDE: side_q <= pwdata[1:0];
				ckdc_pkg::REG_NEAR: near_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			ckdc_pkg::REG_SIDE: prdata = {30'd0, side_q};
			ckdc_pkg::REG_NEAR: prdata = {24'd0, near_q};
			default:            prdata = '0;
		endcase
	end

	assign in_stall = !room;
	assign accept   = in_valid && room;

	ckdc_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.row           (COORD_BITS'(point_row)),
		.col           (COORD_BITS'(point_col)),
		.last          (last_point),
		.side          (side_q),
		.near_distance (near_q),
		.push          (push),
		.ev0           (ev0),
		.ev1           (ev1)
	);

	ckdc_queue #(.DW(EW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.d0     (ev0),
		.d1     (ev1),
		.pop    (pop),
		.head   (head),
		.head_v (head_v),
		.room   (room)
	);

	ckdc_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.head_v        (head_v),
		.pop           (pop),
		.side          (side_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.key_row       (key_row),
		.key_col       (key_col),
		.key_index     (key_index),
		.has_direction (has_direction),
		.direction     (direction),
		.last_key      (last_key)
	);

endmodule

// File: sv/ckdc_checker.sv
// Port-level checks for the contour keypoint direction coder, bound to the top level.
module ckdc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] key_row,
	input logic [7:0] key_col,
	input logic [7:0] key_index,
	input logic       has_direction,
	input logic [2:0] direction,
	input logic       last_key
);

	// hold a stalled keypoint
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_row) && $stable(key_col)
			&& $stable(key_index) && $stable(direction) && $stable(last_key))
		else $error("stalled keypoint changed");

	// the first keypoint of a profile has index zero, no code and is never the last
	a_first_key: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_direction |-> key_index == 8'd0 && direction == 3'd0 && !last_key)
		else $error("malformed first keypoint");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

endmodule

bind contour_keypoint_direction_coder ckdc_checker u_ckdc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.key_row       (key_row),
	.key_col       (key_col),
	.key_index     (key_index),
	.has_direction (has_direction),
	.direction     (direction),
	.last_key      (last_key)
);

// File: bench/contour_keypoint_direction_coder_tb.sv
// Testbench for the contour keypoint direction coder: directed and random profiles.
`timescale 1ns / 1ps

module contour_keypoint_direction_coder_tb;

	typedef struct packed {
		logic [7:0] row;
		logic [7:0] col;
		logic       last;
	} point_t;

	typedef struct packed {
		logic [7:0]          row;
		logic [7:0]          col;
		logic [7:0]          index;
		logic                has_dir;
		ckdc_pkg::dir_code_t dir;
		logic                last;
	} keypoint_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  point_row = 8'd0;
	logic [7:0]  point_col = 8'd0;
	logic        last_point = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  key_row;
	logic [7:0]  key_col;
	logic [7:0]  key_index;
	logic        has_direction;
	logic [2:0]  direction;
	logic        last_key;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	contour_keypoint_direction_coder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.point_row(point_row),
		.point_col(point_col),
		.last_point(last_point),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_row(key_row),
		.key_col(key_col),
		.key_index(key_index),
		.has_direction(has_direction),
		.direction(direction),
		.last_key(last_key),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #10 clk = ~clk;

	// Register shadows and profile state of the predictor
	logic [1:0] side_cfg = ckdc_pkg::SIDE_RESET;
	logic [7:0] near_cfg = ckdc_pkg::NEAR_RESET;
	logic [7:0] win_row [3] = '{8'd0, 8'd0, 8'd0};
	logic [7:0] win_col [3] = '{8'd0, 8'd0, 8'd0};
	int         points_seen = 0;
	logic [7:0] anchor_row = 8'd0;
	logic [7:0] anchor_col = 8'd0;
	int         taken_before = ckdc_pkg::STEP_RESET;
	int         taken_after = ckdc_pkg::STEP_RESET;
	logic [7:0] key_ordinal = 8'd0;

	point_t    pending_points [$];
	keypoint_t expected_keys [$];
	int        queued_points = 0;
	int        accepted_points = 0;
	int        fail_count = 0;
	int        send_gap = 0;
	int        stall_left = 0;
	bit        sender_calm = 1'b0;
	bit        receiver_calm = 1'b0;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Octant of the step from the last keypoint to (r, c)
	function automatic ckdc_pkg::dir_code_t octant_of(logic [7:0] r, logic [7:0] c);
		int     dr, dc, num, den;
		bit     neg;
		longint a, b, q;
		dr = int'(r) - int'(anchor_row);
		dc = int'(anchor_col) - int'(c);
		if (side_cfg[0] == 1'b0) begin
			num = dr;
			den = dc;
		end else begin
			num = dc;
			den = dr;
		end
		if (num == 0)
			return ckdc_pkg::DIR_P00;
		if (den == 0)
			return ckdc_pkg::DIR_P67;
		neg = (num < 0) != (den < 0);
		if (side_cfg == ckdc_pkg::SIDE_RIGHT)
			neg = !neg;
		a = (num < 0) ? -num : num;
		b = (den < 0) ? -den : den;
		q = a << ckdc_pkg::Q_SHIFT;
		if (!neg) begin
			if (q >= longint'(ckdc_pkg::Q16_T67) * b) return ckdc_pkg::DIR_P67;
			if (q >= longint'(ckdc_pkg::Q16_T45) * b) return ckdc_pkg::DIR_P45;
			if (q >= longint'(ckdc_pkg::Q16_T22) * b) return ckdc_pkg::DIR_P22;
			return ckdc_pkg::DIR_P00;
		end
		if (q <= longint'(ckdc_pkg::Q16_T22) * b) return ckdc_pkg::DIR_N00;
		if (q <= longint'(ckdc_pkg::Q16_T45) * b) return ckdc_pkg::DIR_N22;
		if (q <= longint'(ckdc_pkg::Q16_T67) * b) return ckdc_pkg::DIR_N45;
		return ckdc_pkg::DIR_N67;
	endfunction

	task automatic record_key(logic [7:0] r, logic [7:0] c, bit with_dir, bit closing);
		keypoint_t k;
		k.row = r;
		k.col = c;
		k.index = key_ordinal;
		k.has_dir = with_dir;
		k.dir = with_dir ? octant_of(r, c) : ckdc_pkg::DIR_P67;
		k.last = closing;
		expected_keys = {expected_keys, k};
		key_ordinal = key_ordinal + 8'd1;
		anchor_row = r;
		anchor_col = c;
	endtask

	task automatic take_point(logic [7:0] r, logic [7:0] c, logic closing);
		int s0, s1, nd;
		bit flat_or_mono, near_anchor, repeated;
		if (points_seen == 0) begin
			record_key(r, c, 1'b0, 1'b0);
		end else if (points_seen >= 3) begin
			if (side_cfg[0] == 1'b0) begin
				s0 = int'(win_row[1]) - int'(win_row[0]);
				s1 = int'(win_row[2]) - int'(win_row[1]);
			end else begin
				s0 = int'(win_col[1]) - int'(win_col[0]);
				s1 = int'(win_col[2]) - int'(win_col[1]);
			end
			flat_or_mono = (s0 > 0 && s1 > 0) || (s0 < 0 && s1 < 0) || (s0 == 0 && s1 == 0);
			if (!flat_or_mono) begin
				nd = int'(near_cfg);
				near_anchor = (int'(win_col[1]) - int'(anchor_col) <= nd) &&
					(int'(win_row[1]) - int'(anchor_row) <= nd);
				repeated = (taken_before == s0) && (taken_after == s1);
				if (!near_anchor && !repeated) begin
					record_key(win_row[1], win_col[1], 1'b1, 1'b0);
					taken_before = s0;
					taken_after = s1;
				end
			end
		end
		win_row[0] = win_row[1];
		win_row[1] = win_row[2];
		win_row[2] = r;
		win_col[0] = win_col[1];
		win_col[1] = win_col[2];
		win_col[2] = c;
		if (closing) begin
			record_key(r, c, 1'b1, 1'b1);
			win_row = '{8'd0, 8'd0, 8'd0};
			win_col = '{8'd0, 8'd0, 8'd0};
			points_seen = 0;
			anchor_row = 8'd0;
			anchor_col = 8'd0;
			taken_before = ckdc_pkg::STEP_RESET;
			taken_after = ckdc_pkg::STEP_RESET;
			key_ordinal = 8'd0;
		end else if (points_seen < 255) begin
			points_seen++;
		end
	endtask

	// Point driver: hold the request while stalled, advance on acceptance
	always @(posedge clk) begin : point_driver
		point_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				take_point(point_row, point_col, last_point);
				accepted_points++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_points.size() > 0) begin
					nxt = pending_points.pop_front();
					point_row <= nxt.row;
					point_col <= nxt.col;
					last_point <= nxt.last;
					in_valid <= 1'b1;
					send_gap = sender_calm ? 0 : pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Keypoint monitor and output stall generator
	always @(posedge clk) begin : key_monitor
		keypoint_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.row = key_row;
				got.col = key_col;
				got.index = key_index;
				got.has_dir = has_direction;
				got.dir = ckdc_pkg::dir_code_t'(direction);
				got.last = last_key;
				if (expected_keys.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: keypoint with none expected: row=%0d col=%0d idx=%0d",
							$realtime, got.row, got.col, got.index);
				end else begin
					want = expected_keys.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: keypoint mismatch: expected row=%0d col=%0d idx=%0d ",
								"hd=%0d dir=%0d last=%0d, got row=%0d col=%0d idx=%0d ",
								"hd=%0d dir=%0d last=%0d"}, $realtime,
								want.row, want.col, want.index, want.has_dir, want.dir,
								want.last, got.row, got.col, got.index, got.has_dir,
								got.dir, got.last);
					end
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
				stall_left = receiver_calm ? 0 : pick_gap();
			end
		end
	end

	task automatic cfg_write(logic reg_sel, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_sel == ckdc_pkg::REG_SIDE)
			side_cfg = value[1:0];
		else
			near_cfg = value[7:0];
	endtask

	task automatic add_point(int r, int c, bit closing);
		point_t p;
		p.row = r[7:0];
		p.col = c[7:0];
		p.last = closing;
		pending_points = {pending_points, p};
		queued_points++;
	endtask

	// Hold new points until every queued point is taken and every keypoint is out
	task automatic wait_drained();
		int spin;
		spin = 0;
		while ((accepted_points < queued_points || expected_keys.size() != 0) && spin < 50000) begin
			@(posedge clk);
			spin++;
		end
		repeat (8) @(posedge clk);
	endtask

	function automatic int clamp_coord(int v);
		return (v < 0) ? 0 : ((v > 255) ? 255 : v);
	endfunction

	// Shapes: 0 noise, 1 zigzag walk along the side's axis, 2 plateaus, 3 strict zigzag
	task automatic add_profile(int len, int shape);
		int ax, lat, dir, run, mag, i;
		ax = $urandom_range(0, 255);
		lat = $urandom_range(0, 120);
		dir = 1;
		run = 0;
		for (i = 0; i < len; i++) begin
			case (shape)
				0: begin
					ax = $urandom_range(0, 255);
					lat = $urandom_range(0, 255);
				end
				1: begin
					if (run == 0) begin
						dir = -dir;
						run = $urandom_range(1, 3);
					end
					run--;
					mag = $urandom_range(0, 1) ? $urandom_range(0, 30) : 10;
					ax = clamp_coord(ax + dir * mag);
					lat = clamp_coord(lat + $urandom_range(0, 35) - 10);
				end
				2: begin
					if ($urandom_range(0, 3) == 0) begin
						ax = $urandom_range(0, 255);
						lat = $urandom_range(0, 255);
					end
				end
				default: begin
					if (i % 2 == 0) begin
						ax = 100 + $urandom_range(0, 50);
						lat = $urandom_range(0, 50);
					end else begin
						ax = $urandom_range(0, 50);
						lat = 200 + $urandom_range(0, 55);
					end
				end
			endcase
			if (side_cfg[0] == 1'b0)
				add_point(ax, lat, i == len - 1);
			else
				add_point(lat, ax, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int phase, budget, len;
		int near_pick [4] = '{0, 255, 5, 20};
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: single-point profiles at both extremes, then a zigzag
		add_point(0, 0, 1'b1);
		add_point(255, 255, 1'b1);
		add_point(0, 0, 1'b0);
		add_point(40, 10, 1'b0);
		add_point(0, 20, 1'b0);
		add_point(40, 30, 1'b0);
		add_point(0, 40, 1'b0);
		add_point(255, 255, 1'b1);
		wait_drained();

		// Repeated step pair after a dropped near candidate, flat step, vertical step
		cfg_write(ckdc_pkg::REG_SIDE, 32'd0);
		cfg_write(ckdc_pkg::REG_NEAR, 32'd0);
		add_point(0, 0, 1'b0);
		add_point(10, 5, 1'b0);
		add_point(0, 5, 1'b0);
		add_point(10, 6, 1'b0);
		add_point(0, 7, 1'b0);
		add_point(50, 50, 1'b1);
		add_point(5, 200, 1'b0);
		add_point(5, 100, 1'b1);
		add_point(10, 10, 1'b0);
		add_point(10, 10, 1'b0);
		add_point(200, 10, 1'b1);
		wait_drained();

		// Mirrored side on the column axis
		cfg_write(ckdc_pkg::REG_SIDE, {30'd0, ckdc_pkg::SIDE_RIGHT});
		add_point(0, 0, 1'b0);
		add_point(10, 60, 1'b0);
		add_point(20, 0, 1'b0);
		add_point(30, 60, 1'b0);
		add_point(40, 0, 1'b0);
		add_point(0, 255, 1'b1);
		wait_drained();

		for (phase = 0; phase < 11; phase++) begin
			sender_calm = ($urandom_range(0, 3) == 0);
			receiver_calm = ($urandom_range(0, 3) == 0);
			cfg_write(ckdc_pkg::REG_SIDE, phase % 4);
			if (phase == 5)
				cfg_write(ckdc_pkg::REG_NEAR, 32'd0);
			else
				cfg_write(ckdc_pkg::REG_NEAR,
					(phase > 7) ? $urandom_range(0, 255) : near_pick[phase % 4]);
			if (phase == 5) begin
				// long profile: index wraps, point count saturates
				add_profile(280, 3);
			end else begin
				budget = 0;
				while (budget < 62) begin
					len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) :
						$urandom_range(1, 12);
					case ($urandom_range(0, 9))
						0, 1: add_profile(len, 0);
						2: add_profile(len, 2);
						default: add_profile(len, 1);
					endcase
					budget += len;
				end
			end
			wait_drained();
		end

		if (fail_count == 0 && expected_keys.size() == 0 && accepted_points == queued_points)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
